// File: src/skce_pkg.sv
package skce_pkg;

  localparam int MAX_KMER_LENGTH = 31;
  localparam int WIN_W           = 2 * MAX_KMER_LENGTH;
  localparam int KEY_BASES       = MAX_KMER_LENGTH - 1;
  localparam int KEY_W           = 2 * KEY_BASES;
  localparam int RUN_W           = $clog2(MAX_KMER_LENGTH + 1);
  localparam int HL_W            = 4;
  localparam int HALF_MAX        = (MAX_KMER_LENGTH - 1) / 2;
  localparam int HALF_RESET      = 15;
  localparam int SHIFT_W         = $clog2(KEY_W + 1);

  typedef logic [1:0] base_t;

  localparam base_t BASE_A = 2'd0;
  localparam base_t BASE_C = 2'd1;
  localparam base_t BASE_G = 2'd2;
  localparam base_t BASE_T = 2'd3;

  localparam logic [7:0] CHAR_A_UP = 8'h41;
  localparam logic [7:0] CHAR_C_UP = 8'h43;
  localparam logic [7:0] CHAR_G_UP = 8'h47;
  localparam logic [7:0] CHAR_T_UP = 8'h54;
  localparam logic [7:0] CHAR_A_LO = 8'h61;
  localparam logic [7:0] CHAR_C_LO = 8'h63;
  localparam logic [7:0] CHAR_G_LO = 8'h67;
  localparam logic [7:0] CHAR_T_LO = 8'h74;

  // Forward split k-mer held between the window stage and the canonical stage
  typedef struct packed {
    logic [KEY_W-1:0] fwd;
    base_t            middle;
    logic [HL_W-1:0]  half;
  } stage_t;

endpackage

// File: src/skce_if.sv
interface skce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       new_contig;

  modport source (output valid, output base_char, output new_contig, input ready);
  modport sink   (input valid, input base_char, input new_contig, output ready);
endinterface

interface skce_out_if;
  logic                    valid;
  logic                    ready;
  logic [skce_pkg::KEY_W-1:0] canonical_key;
  skce_pkg::base_t         middle_base;

  modport source (output valid, output canonical_key, output middle_base, input ready);
  modport sink   (input valid, input canonical_key, input middle_base, output ready);
endinterface

// File: src/skce_window.sv
module skce_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [skce_pkg::HL_W-1:0] half_length,
  skce_in_if.sink                   in_chan,
  input  logic                      stage_ready,
  output logic                      stage_valid,
  output skce_pkg::stage_t          stage
);

  logic [skce_pkg::WIN_W-1:0] base_window;
  logic [skce_pkg::WIN_W-1:0] base_window_next;
  logic [skce_pkg::RUN_W-1:0] valid_run;
  logic [skce_pkg::RUN_W-1:0] valid_run_next;
  logic [skce_pkg::HL_W-1:0]  half;
  logic [skce_pkg::RUN_W-1:0] kmer_len;
  logic                       base_ok;
  skce_pkg::base_t            code;
  logic [skce_pkg::WIN_W-1:0] win_base;
  logic [skce_pkg::WIN_W-1:0] side_mask;
  logic [skce_pkg::WIN_W-1:0] left;
  logic [skce_pkg::WIN_W-1:0] right;
  logic [skce_pkg::WIN_W-1:0] joined;
  logic                       accept;
  logic                       emit;
  skce_pkg::stage_t           stage_next;

  always_comb begin
    base_ok = 1'b1;
    code    = skce_pkg::BASE_A;
    case (in_chan.base_char)
      skce_pkg::CHAR_A_UP, skce_pkg::CHAR_A_LO: code = skce_pkg::BASE_A;
      skce_pkg::CHAR_C_UP, skce_pkg::CHAR_C_LO: code = skce_pkg::BASE_C;
      skce_pkg::CHAR_G_UP, skce_pkg::CHAR_G_LO: code = skce_pkg::BASE_G;
      skce_pkg::CHAR_T_UP, skce_pkg::CHAR_T_LO: code = skce_pkg::BASE_T;
      default:                                  base_ok = 1'b0;
    endcase
  end

  // clamp the half length into the supported range
  always_comb begin
    half = half_length;
    if (half_length == '0) begin
      half = skce_pkg::HL_W'(1);
    end else if (half_length > skce_pkg::HL_W'(skce_pkg::HALF_MAX)) begin
      half = skce_pkg::HL_W'(skce_pkg::HALF_MAX);
    end
    kmer_len = skce_pkg::RUN_W'({half, 1'b1});
  end

  always_comb begin
    win_base = in_chan.new_contig ? '0 : base_window;
    if (base_ok) begin
      base_window_next = {win_base[skce_pkg::WIN_W-3:0], code};
      if (in_chan.new_contig) begin
        valid_run_next = skce_pkg::RUN_W'(1);
      end else if (valid_run < skce_pkg::RUN_W'(skce_pkg::MAX_KMER_LENGTH)) begin
        valid_run_next = valid_run + skce_pkg::RUN_W'(1);
      end else begin
        valid_run_next = valid_run;
      end
    end else begin
      base_window_next = '0;
      valid_run_next   = '0;
    end
    emit = base_ok && (valid_run_next >= kmer_len);
  end

  // pull the outer bases either side of the middle base together
  always_comb begin
    side_mask = (skce_pkg::WIN_W'(1) << {half, 1'b0}) - skce_pkg::WIN_W'(1);
    right     = base_window_next & side_mask;
    left      = (base_window_next >> ({1'b0, half, 1'b0} + 6'd2)) & side_mask;
    joined    = (left << {half, 1'b0}) | right;
    stage_next.fwd    = joined[skce_pkg::KEY_W-1:0];
    stage_next.middle = skce_pkg::base_t'(base_window_next >> {half, 1'b0});
    stage_next.half   = half;
  end

  assign in_chan.ready = !stage_valid || stage_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_window <= '0;
      valid_run   <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (accept) begin
        base_window <= base_window_next;
        valid_run   <= valid_run_next;
        stage_valid <= emit;
      end else if (stage_ready) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

// File: src/skce_canon.sv
module skce_canon (
  input  logic             clk,
  input  logic             rst,
  input  logic             stage_valid,
  input  skce_pkg::stage_t stage,
  output logic             stage_ready,
  skce_out_if.source       out_chan
);

  logic [skce_pkg::KEY_W-1:0]   comp;
  logic [skce_pkg::KEY_W-1:0]   flipped;
  logic [skce_pkg::KEY_W-1:0]   rev;
  logic [skce_pkg::SHIFT_W-1:0] rshift;
  logic                         use_rev;
  logic                         load;

  // complement, reverse base order, then drop the unused low bases
  always_comb begin
    comp = ~stage.fwd;
    for (int i = 0; i < skce_pkg::KEY_BASES; i++) begin
      flipped[2*i +: 2] = comp[2*(skce_pkg::KEY_BASES-1-i) +: 2];
    end
    rshift  = skce_pkg::SHIFT_W'(skce_pkg::KEY_W) - skce_pkg::SHIFT_W'({stage.half, 2'b00});
    rev     = flipped >> rshift;
    use_rev = rev < stage.fwd;
  end

  assign stage_ready = !out_chan.valid || out_chan.ready;
  assign load        = stage_valid && stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else begin
      if (load) begin
        out_chan.valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_chan.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_chan.canonical_key <= use_rev ? rev : stage.fwd;
      out_chan.middle_base   <= use_rev ? ~stage.middle : stage.middle;
    end
  end

endmodule

// File: src/split_kmer_canonical_extractor_top.sv
// Pipeline: two register stages; an accepted request's split k-mer is registered in the window
// stage, then its canonical result in the output register of the canonical stage.
// Throughput: one request per cycle while the input is ready; the window stage stalls only
// when it holds a split k-mer and the result register holds a result while the output is not ready.
// Reset (rst, synchronous, active high): window and run count cleared, half length set
// to 15, both stages emptied.
module split_kmer_canonical_extractor_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [skce_pkg::HL_W-1:0] cfg_wdata,
  skce_in_if.sink                   in_chan,
  skce_out_if.source                out_chan
);

  // Half-length register; the user must write it only while the block is idle, as the block leaves this unchecked
  logic [skce_pkg::HL_W-1:0] half_length;

  // Window stage to canonical stage
  logic             stage_valid;
  logic             stage_ready;
  skce_pkg::stage_t stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= skce_pkg::HL_W'(skce_pkg::HALF_RESET);
    end else if (cfg_we) begin
      half_length <= cfg_wdata;
    end
  end

  // Decode the character, advance the rolling window and run count, and hold the
  // forward split k-mer whenever the run has reached k bases. Drop requests that
  // give no result here.
  skce_window u_window (
    .clk         (clk),
    .rst         (rst),
    .half_length (half_length),
    .in_chan     (in_chan),
    .stage_ready (stage_ready),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // Build the reverse complement, keep the smaller strand and register the result.
  skce_canon u_canon (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_ready (stage_ready),
    .out_chan    (out_chan)
  );

endmodule

// File: test/split_kmer_canonical_extractor_top_test.sv
module split_kmer_canonical_extractor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Give up long after the slowest honest run could have finished.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;
  // Settle time after the last expected result: two stages of latency plus margin.
  localparam int SETTLE_CYCLES = 4;
  localparam int CHUNKS        = 7;
  localparam int CHUNK_ITEMS   = 200;
  localparam int DIR_ROWS      = 24;

  // One split k-mer as it leaves the block.
  typedef struct packed {
    logic [skce_pkg::KEY_W-1:0] key;
    skce_pkg::base_t            middle;
  } kmer_t;

  // How a directed row is checked, or whether it is a register write instead.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_TYPED,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [7:0]                 ch;
    logic                       nc;
    logic [skce_pkg::HL_W-1:0]  half;
    logic [skce_pkg::KEY_W-1:0] key;
    skce_pkg::base_t            middle;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [skce_pkg::HL_W-1:0] cfg_wdata;

  skce_in_if  in_chan ();
  skce_out_if out_chan ();

  split_kmer_canonical_extractor_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // Shadow copy of the block's state and its one register.
  logic [skce_pkg::WIN_W-1:0] model_window;
  logic [skce_pkg::RUN_W-1:0] model_run;
  logic [skce_pkg::HL_W-1:0]  model_half;

  // Split k-mers predicted for accepted requests, oldest first.
  kmer_t pending_kmers [$];

  int fault_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 10;
  int recv_stall_pct = 50;

  // Directed rows. Starts under the reset half length of 15, so nothing may
  // come out until the register is lowered.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_QUIET,   skce_pkg::CHAR_A_UP, 1'b1, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_QUIET,   skce_pkg::CHAR_C_LO, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_QUIET,   8'h4E,               1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},  // N breaks
    '{ROW_QUIET,   8'hFF,               1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_CONFIG,  8'h00,               1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},  // k = 3
    '{ROW_QUIET,   skce_pkg::CHAR_A_UP, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_QUIET,   skce_pkg::CHAR_A_UP, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_TYPED,   skce_pkg::CHAR_A_UP, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},  // AAA
    '{ROW_TYPED,   skce_pkg::CHAR_T_UP, 1'b0, 4'd0, 60'd3, skce_pkg::BASE_A},  // AAT tie
    '{ROW_TYPED,   skce_pkg::CHAR_T_LO, 1'b0, 4'd0, 60'd3, skce_pkg::BASE_T},  // ATT tie
    '{ROW_QUIET,   skce_pkg::CHAR_G_UP, 1'b1, 4'd0, 60'd0, skce_pkg::BASE_A},  // new contig
    '{ROW_QUIET,   skce_pkg::CHAR_G_LO, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_TYPED,   skce_pkg::CHAR_G_LO, 1'b0, 4'd0, 60'd5, skce_pkg::BASE_C},  // GGG rev
    '{ROW_TYPED,   skce_pkg::CHAR_C_UP, 1'b0, 4'd0, 60'd9, skce_pkg::BASE_G},  // GGC tie
    '{ROW_CONFIG,  8'h00,               1'b0, 4'd2, 60'd0, skce_pkg::BASE_A},  // k grows
    '{ROW_PREDICT, skce_pkg::CHAR_A_LO, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_PREDICT, skce_pkg::CHAR_C_UP, 1'b1, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_QUIET,   8'h55,               1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},  // U
    '{ROW_QUIET,   8'h00,               1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_QUIET,   8'h80,               1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_CONFIG,  8'h00,               1'b0, 4'd1, 60'd0, skce_pkg::BASE_A},
    '{ROW_QUIET,   skce_pkg::CHAR_T_UP, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_QUIET,   skce_pkg::CHAR_T_LO, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A},
    '{ROW_TYPED,   skce_pkg::CHAR_T_UP, 1'b0, 4'd0, 60'd0, skce_pkg::BASE_A}   // TTT rev
  };

  // Register values per random chunk; chunk five draws its own value.
  int half_plan [CHUNKS] = '{15, 1, 0, 7, 15, 0, 3};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shift one character into the shadow window and work out the split k-mer,
  // if the run is long enough to give one.
  task automatic advance_kmer_window(input logic [7:0] ch, input logic nc,
                                     output bit hit, output kmer_t res);
    int              h;
    bit              is_base;
    skce_pkg::base_t b;
    skce_pkg::base_t mid;
    logic [63:0]     side_mask;
    logic [63:0]     fwd;
    logic [63:0]     rev;
    hit = 1'b0;
    res = '0;
    if (nc) begin
      model_window = '0;
      model_run    = '0;
    end
    is_base = 1'b1;
    case (ch)
      skce_pkg::CHAR_A_UP, skce_pkg::CHAR_A_LO: b = skce_pkg::BASE_A;
      skce_pkg::CHAR_C_UP, skce_pkg::CHAR_C_LO: b = skce_pkg::BASE_C;
      skce_pkg::CHAR_G_UP, skce_pkg::CHAR_G_LO: b = skce_pkg::BASE_G;
      skce_pkg::CHAR_T_UP, skce_pkg::CHAR_T_LO: b = skce_pkg::BASE_T;
      default: begin
        b       = skce_pkg::BASE_A;
        is_base = 1'b0;
      end
    endcase
    if (!is_base) begin
      // Anything but a base drops the whole run.
      model_window = '0;
      model_run    = '0;
    end else begin
      model_window = {model_window[skce_pkg::WIN_W-3:0], b};
      if (model_run < skce_pkg::MAX_KMER_LENGTH) model_run = model_run + 1'b1;
      // Clamp the register into the legal range of half lengths.
      if (model_half == 0) h = 1;
      else if (model_half > skce_pkg::HALF_MAX) h = skce_pkg::HALF_MAX;
      else h = int'(model_half);
      if (model_run >= 2 * h + 1) begin
        side_mask = (64'd1 << (2 * h)) - 64'd1;
        mid = skce_pkg::base_t'(model_window >> (2 * h));
        fwd = ((64'(model_window) >> (2 * h + 2)) & side_mask) << (2 * h);
        fwd = fwd | (64'(model_window) & side_mask);
        // Reverse complement: walk the 2h outer bases from the newest and
        // append each complement, so the newest ends up most significant.
        rev = '0;
        for (int i = 0; i < 2 * h; i++) rev = {rev[61:0], ~fwd[2*i +: 2]};
        hit = 1'b1;
        if (rev < fwd) begin
          res.key    = rev[skce_pkg::KEY_W-1:0];
          res.middle = ~mid;
        end else begin
          res.key    = fwd[skce_pkg::KEY_W-1:0];
          res.middle = mid;
        end
      end
    end
  endtask

  // Offer one request, hold it until taken, then book what it should produce.
  // Valid is left high on return so back-to-back requests need no second drive.
  task automatic send_request(input logic [7:0] ch, input logic nc,
                              input row_kind_e kind, input kmer_t typed);
    bit    hit;
    kmer_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.base_char  <= ch;
    in_chan.new_contig <= nc;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    advance_kmer_window(ch, nc, hit, res);
    case (kind)
      ROW_TYPED:   pending_kmers = {pending_kmers, typed};
      ROW_PREDICT: if (hit) pending_kmers = {pending_kmers, res};
      default:     ;
    endcase
  endtask

  // Hold the input quiet until every booked result has come out, then let the
  // pipeline settle; requests that give no result may still be in flight.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_kmers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_length(input logic [skce_pkg::HL_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_half  = value;
  endtask

  function automatic logic [7:0] char_of_base(input skce_pkg::base_t b, input bit lower);
    logic [7:0] ch;
    case (b)
      skce_pkg::BASE_A: ch = lower ? skce_pkg::CHAR_A_LO : skce_pkg::CHAR_A_UP;
      skce_pkg::BASE_C: ch = lower ? skce_pkg::CHAR_C_LO : skce_pkg::CHAR_C_UP;
      skce_pkg::BASE_G: ch = lower ? skce_pkg::CHAR_G_LO : skce_pkg::CHAR_G_UP;
      default:          ch = lower ? skce_pkg::CHAR_T_LO : skce_pkg::CHAR_T_UP;
    endcase
    return ch;
  endfunction

  // Receiver: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every delivered split k-mer with the oldest booked one.
  always @(posedge clk) begin
    kmer_t want;
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (pending_kmers.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected result: key %h middle %0d",
                   out_chan.canonical_key, out_chan.middle_base);
      end else begin
        want = pending_kmers.pop_front();
        if (out_chan.canonical_key !== want.key || out_chan.middle_base !== want.middle) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("mismatch: key %h middle %0d, expected key %h middle %0d",
                     out_chan.canonical_key, out_chan.middle_base, want.key, want.middle);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    kmer_t           typed;
    logic [7:0]      ch;
    logic            nc;
    skce_pkg::base_t b;
    skce_pkg::base_t last_base;
    int              pick;
    int              half;
    // Drive every input to a known value from time zero.
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.base_char  = '0;
    in_chan.new_contig = 1'b0;
    out_chan.ready     = 1'b0;
    model_window       = '0;
    model_run          = '0;
    model_half         = 4'd15;
    last_base          = skce_pkg::BASE_A;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk the table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        write_half_length(directed_rows[i].half);
      end else begin
        typed.key    = directed_rows[i].key;
        typed.middle = directed_rows[i].middle;
        send_request(directed_rows[i].ch, directed_rows[i].nc, directed_rows[i].kind, typed);
      end
    end

    // Random part: chunks under different half lengths, the window carried
    // across each register write so length changes land mid-run.
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk < 3) begin
        send_idle_pct  = 10;
        recv_stall_pct = 50;
      end else if (chunk < 5) begin
        send_idle_pct  = 50;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      half = (chunk == 5) ? $urandom_range(15) : half_plan[chunk];
      write_half_length(skce_pkg::HL_W'(half));
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          // Noise: any byte at all, nearly always a break.
          ch = 8'($urandom_range(255));
        end else begin
          // Mostly clean sequence; repeats push toward ties and extreme keys.
          b         = (pick < 25) ? last_base : skce_pkg::base_t'($urandom_range(3));
          last_base = b;
          ch        = char_of_base(b, 1'($urandom_range(1)));
        end
        nc = ($urandom_range(99) == 0);
        send_request(ch, nc, ROW_PREDICT, '0);
      end
    end

    drain_results();
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
